### rtl/descriptor_slot_table_assert.svh
// Assertion macros for the descriptor slot table.
// Included by files that check their own logic; needs nothing else.
`ifndef DESCRIPTOR_SLOT_TABLE_ASSERT_SVH
`define DESCRIPTOR_SLOT_TABLE_ASSERT_SVH

// Implication checked at every rising edge outside reset.
`define DST_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("descriptor_slot_table: check failed");

// Condition that holds at every rising edge outside reset.
`define DST_ASSERT_ALWAYS(lbl, clk_s, rst_s, cond) \
	`DST_ASSERT_IMPL(lbl, clk_s, rst_s, 1'b1, cond)

`endif

### rtl/dst_pkg.sv
// Shared types, codes and constants of the descriptor slot table.
// Depends on nothing; used by the interfaces, the RAM and the top level.
package dst_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int HANDLE_BITS_DEF = 16;

	localparam int OP_W       = 3;
	localparam int SLOT_NUM_W = 8;
	localparam int FH_W       = 16;
	localparam int STATUS_W   = 2;
	localparam int SLOT_OUT_W = 6;
	localparam int HOUT_W     = 16;
	localparam int REF_W      = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC   = 3'd0,
		OP_GET     = 3'd1,
		OP_CLOSE   = 3'd2,
		OP_DUP     = 3'd3,
		OP_DESTROY = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK         = 2'd0,
		STAT_FULL       = 2'd1,
		STAT_BAD_HANDLE = 2'd2,
		STAT_NOT_OPEN   = 2'd3
	} status_t;

	typedef enum logic [REF_W-1:0] {
		REF_NONE = 2'd0,
		REF_ADD  = 2'd1,
		REF_DROP = 2'd2
	} ref_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_SCAN,
		S_FLUSH
	} state_t;

	typedef struct packed {
		status_t                 status;
		logic [SLOT_OUT_W-1:0]   slot;
		logic [HOUT_W-1:0]       handle;
		ref_t                    ref_action;
	} res_t;

	function automatic res_t mk_res(status_t s, logic [SLOT_OUT_W-1:0] sl,
		logic [HOUT_W-1:0] h, ref_t r);
		res_t v;
		v.status     = s;
		v.slot       = sl;
		v.handle     = h;
		v.ref_action = r;
		return v;
	endfunction

endpackage

### rtl/dst_cmd_if.sv
// Command channel of the descriptor slot table: valid, ready and one request word.
// Depends on dst_pkg for the field widths.
interface dst_cmd_if;
	logic                            valid;
	logic                            ready;
	logic [dst_pkg::OP_W-1:0]        operation;
	logic [dst_pkg::SLOT_NUM_W-1:0]  slot_number;
	logic [dst_pkg::FH_W-1:0]        file_handle;

	modport source (output valid, operation, slot_number, file_handle, input ready);
	modport sink (input valid, operation, slot_number, file_handle, output ready);
endinterface

### rtl/dst_rsp_if.sv
// Response channel of the descriptor slot table: valid, ready and one result word.
// Depends on dst_pkg for the field widths.
interface dst_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [dst_pkg::STATUS_W-1:0]    status;
	logic [dst_pkg::SLOT_OUT_W-1:0]  slot_out;
	logic [dst_pkg::HOUT_W-1:0]      handle_out;
	logic [dst_pkg::REF_W-1:0]       ref_action;
	logic                            last;

	modport source (output valid, status, slot_out, handle_out, ref_action, last,
		input ready);
	modport sink (input valid, status, slot_out, handle_out, ref_action, last,
		output ready);
endinterface

### rtl/dst_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on dst_pkg for default sizes only.
module dst_ram #(
	parameter int WIDTH = dst_pkg::HANDLE_BITS_DEF,
	parameter int DEPTH = dst_pkg::TABLE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/descriptor_slot_table.sv
// Descriptor slot table: slots of file handles kept in one synchronous RAM.
// Depends on dst_pkg, dst_cmd_if, dst_rsp_if, dst_ram and the assertion header.
//
// Usage: one request word enters on cmd (operation, slot_number, file_handle);
// result words leave on rsp, the final one of each request flagged by last.
// Alloc, get, close and dup give one word; destroy gives one word per occupied
// slot, or none for an empty table; unknown operations give nothing.
// Get, close and dup of an in-range slot read it in a lookup state before the
// result is formed; an out-of-range slot or a null alloc handle skips the RAM.
// Alloc and dup walk the RAM from slot zero, one read per cycle, until a free
// slot or the end of the table. Destroy walks every slot; each time a slot's
// word finds the output register still full, the walk waits for it and rereads
// that slot. One request is worked on at a time; cmd.ready rises again as soon
// as the last result sits in the output register.
// After reset the RAM is swept to zero with cmd.ready low.
// A stalled receiver holds the output register; a destroy then pauses its walk
// and rereads the slot it stopped at once the output frees.
module descriptor_slot_table #(
	parameter int TABLE_DEPTH = dst_pkg::TABLE_DEPTH_DEF,
	parameter int HANDLE_BITS = dst_pkg::HANDLE_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	dst_cmd_if.sink    cmd,
	dst_rsp_if.source  rsp
);

	localparam int SLOT_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = SLOT_W + 1;
	localparam logic [SLOT_W-1:0] LAST_IDX  = SLOT_W'(TABLE_DEPTH - 1);
	localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(TABLE_DEPTH);

	dst_pkg::state_t state_q, state_d;
	dst_pkg::op_t    op_q, op_d;
	dst_pkg::op_t    cmd_op;

	logic [CNT_W-1:0]       cnt_q, cnt_d;
	logic                   chk_vld_s1, chk_vld_d;
	logic [SLOT_W-1:0]      chk_idx_s1, chk_idx_d;
	logic [HANDLE_BITS-1:0] hold_q, hold_d;
	logic [SLOT_W-1:0]      slot_q, slot_d;

	dst_pkg::res_t pend_q, pend_d;
	logic          pend_vld_q, pend_vld_d;
	dst_pkg::res_t out_q, out_d;
	logic          out_last_q, out_last_d;
	logic          out_vld_q, out_vld_d;
	logic          out_free, out_load;

	logic                   mem_we;
	logic [SLOT_W-1:0]      mem_waddr, mem_raddr;
	logic [HANDLE_BITS-1:0] mem_wdata, mem_rdata;

	logic [HANDLE_BITS-1:0]          cmd_h;
	logic [SLOT_W-1:0]               cmd_idx;
	logic                            cmd_in_range;
	logic                            cmd_rdy;
	logic                            rd_zero;
	logic [dst_pkg::HOUT_W-1:0]      rd_h16, hold_h16;
	logic [dst_pkg::SLOT_OUT_W-1:0]  chk_slot6, slot_slot6;

	dst_ram #(
		.WIDTH (HANDLE_BITS),
		.DEPTH (TABLE_DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign cmd_op       = dst_pkg::op_t'(cmd.operation);
	assign cmd_h        = HANDLE_BITS'(cmd.file_handle);
	assign cmd_idx      = SLOT_W'(cmd.slot_number);
	assign cmd_in_range = 32'(cmd.slot_number) < TABLE_DEPTH;
	assign rd_zero      = (mem_rdata == '0);
	assign rd_h16       = dst_pkg::HOUT_W'(mem_rdata);
	assign hold_h16     = dst_pkg::HOUT_W'(hold_q);
	assign chk_slot6    = dst_pkg::SLOT_OUT_W'(chk_idx_s1);
	assign slot_slot6   = dst_pkg::SLOT_OUT_W'(slot_q);
	assign out_free     = !out_vld_q || rsp.ready;

	always_comb begin
		state_d    = state_q;
		op_d       = op_q;
		cnt_d      = cnt_q;
		chk_vld_d  = 1'b0;
		chk_idx_d  = chk_idx_s1;
		hold_d     = hold_q;
		slot_d     = slot_q;
		pend_d     = pend_q;
		pend_vld_d = pend_vld_q;
		out_load   = 1'b0;
		out_d      = out_q;
		out_last_d = out_last_q;
		mem_we     = 1'b0;
		mem_waddr  = chk_idx_s1;
		mem_wdata  = '0;
		mem_raddr  = cnt_q[SLOT_W-1:0];
		cmd_rdy    = 1'b0;

		unique case (state_q)
			dst_pkg::S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q[SLOT_W-1:0];
				if (cnt_q[SLOT_W-1:0] == LAST_IDX) begin
					cnt_d   = '0;
					state_d = dst_pkg::S_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			dst_pkg::S_IDLE: begin
				cmd_rdy   = 1'b1;
				mem_raddr = cmd_idx;
				if (cmd.valid) begin
					op_d   = cmd_op;
					hold_d = cmd_h;
					slot_d = cmd_idx;
					cnt_d  = '0;
					unique case (cmd_op) inside
						dst_pkg::OP_ALLOC: begin
							if (cmd_h == '0) begin
								pend_d = dst_pkg::mk_res(dst_pkg::STAT_BAD_HANDLE, '0, '0,
									dst_pkg::REF_NONE);
								pend_vld_d = 1'b1;
								state_d    = dst_pkg::S_FLUSH;
							end else begin
								state_d = dst_pkg::S_SCAN;
							end
						end
						dst_pkg::OP_GET, dst_pkg::OP_CLOSE, dst_pkg::OP_DUP: begin
							if (!cmd_in_range) begin
								pend_d = dst_pkg::mk_res(dst_pkg::STAT_NOT_OPEN, '0, '0,
									dst_pkg::REF_NONE);
								pend_vld_d = 1'b1;
								state_d    = dst_pkg::S_FLUSH;
							end else begin
								state_d = dst_pkg::S_LOOK;
							end
						end
						dst_pkg::OP_DESTROY: begin
							state_d = dst_pkg::S_SCAN;
						end
						default: begin
						end
					endcase
				end
			end
			dst_pkg::S_LOOK: begin
				if (rd_zero) begin
					pend_d = dst_pkg::mk_res(dst_pkg::STAT_NOT_OPEN, '0, '0,
						dst_pkg::REF_NONE);
					pend_vld_d = 1'b1;
					state_d    = dst_pkg::S_FLUSH;
				end else begin
					case (op_q)
						dst_pkg::OP_GET: begin
							pend_d = dst_pkg::mk_res(dst_pkg::STAT_OK, slot_slot6, rd_h16,
								dst_pkg::REF_NONE);
							pend_vld_d = 1'b1;
							state_d    = dst_pkg::S_FLUSH;
						end
						dst_pkg::OP_CLOSE: begin
							mem_we    = 1'b1;
							mem_waddr = slot_q;
							pend_d = dst_pkg::mk_res(dst_pkg::STAT_OK, slot_slot6, rd_h16,
								dst_pkg::REF_DROP);
							pend_vld_d = 1'b1;
							state_d    = dst_pkg::S_FLUSH;
						end
						default: begin
							hold_d  = mem_rdata;
							state_d = dst_pkg::S_SCAN;
						end
					endcase
				end
			end
			dst_pkg::S_SCAN: begin
				if (cnt_q < DEPTH_CNT) begin
					chk_vld_d = 1'b1;
					chk_idx_d = cnt_q[SLOT_W-1:0];
					cnt_d     = cnt_q + 1'b1;
				end
				if (chk_vld_s1) begin
					if (op_q == dst_pkg::OP_DESTROY) begin
						if (!rd_zero) begin
							if (pend_vld_q && !out_free) begin
								// Output is busy: reread this slot once it frees.
								cnt_d     = {1'b0, chk_idx_s1};
								chk_vld_d = 1'b0;
							end else begin
								mem_we = 1'b1;
								if (pend_vld_q) begin
									out_load   = 1'b1;
									out_d      = pend_q;
									out_last_d = 1'b0;
								end
								pend_d = dst_pkg::mk_res(dst_pkg::STAT_OK, chk_slot6, rd_h16,
									dst_pkg::REF_DROP);
								pend_vld_d = 1'b1;
								if (chk_idx_s1 == LAST_IDX) begin
									state_d = dst_pkg::S_FLUSH;
								end
							end
						end else if (chk_idx_s1 == LAST_IDX) begin
							state_d = dst_pkg::S_FLUSH;
						end
					end else begin
						if (rd_zero) begin
							mem_we    = 1'b1;
							mem_wdata = hold_q;
							pend_d = dst_pkg::mk_res(dst_pkg::STAT_OK, chk_slot6, hold_h16,
								dst_pkg::ref_t'((op_q == dst_pkg::OP_DUP) ? dst_pkg::REF_ADD
									: dst_pkg::REF_NONE));
							pend_vld_d = 1'b1;
							state_d    = dst_pkg::S_FLUSH;
						end else if (chk_idx_s1 == LAST_IDX) begin
							pend_d = dst_pkg::mk_res(dst_pkg::STAT_FULL, '0, '0,
								dst_pkg::REF_NONE);
							pend_vld_d = 1'b1;
							state_d    = dst_pkg::S_FLUSH;
						end
					end
				end
			end
			dst_pkg::S_FLUSH: begin
				if (pend_vld_q) begin
					if (out_free) begin
						out_load   = 1'b1;
						out_d      = pend_q;
						out_last_d = 1'b1;
						pend_vld_d = 1'b0;
						state_d    = dst_pkg::S_IDLE;
					end
				end else begin
					state_d = dst_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = dst_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		if (out_load) begin
			out_vld_d = 1'b1;
		end else if (rsp.ready) begin
			out_vld_d = 1'b0;
		end else begin
			out_vld_d = out_vld_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= dst_pkg::S_CLEAR;
			cnt_q      <= '0;
			chk_vld_s1 <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			chk_vld_s1 <= chk_vld_d;
			pend_vld_q <= pend_vld_d;
			out_vld_q  <= out_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q       <= op_d;
		hold_q     <= hold_d;
		slot_q     <= slot_d;
		chk_idx_s1 <= chk_idx_d;
		pend_q     <= pend_d;
		out_q      <= out_d;
		out_last_q <= out_last_d;
	end

	assign cmd.ready      = cmd_rdy;
	assign rsp.valid      = out_vld_q;
	assign rsp.status     = out_q.status;
	assign rsp.slot_out   = out_q.slot;
	assign rsp.handle_out = out_q.handle;
	assign rsp.ref_action = out_q.ref_action;
	assign rsp.last       = out_last_q;

`include "descriptor_slot_table_assert.svh"

	`DST_ASSERT_IMPL(a_load_into_free_out, clk, arst_n, out_load, !out_vld_q || rsp.ready)
	`DST_ASSERT_IMPL(a_idle_no_pending, clk, arst_n, state_q == dst_pkg::S_IDLE, !pend_vld_q)
	`DST_ASSERT_ALWAYS(a_cnt_in_range, clk, arst_n, cnt_q <= DEPTH_CNT)

endmodule

### sim/tb.sv
// Testbench for descriptor_slot_table: random and directed request words
// checked against a table predictor.
// Depends on dst_pkg, dst_cmd_if, dst_rsp_if and the descriptor_slot_table RTL.
`timescale 1ns / 100ps

module tb;

	localparam int DEPTH = dst_pkg::TABLE_DEPTH_DEF;
	localparam int OP_W = dst_pkg::OP_W;
	localparam int SLOT_NUM_W = dst_pkg::SLOT_NUM_W;
	localparam int FH_W = dst_pkg::FH_W;
	localparam int SLOT_OUT_W = dst_pkg::SLOT_OUT_W;
	localparam int HOUT_W = dst_pkg::HOUT_W;
	localparam int GEN_COPY = 0;
	localparam int PRED_COPY = 1;
	localparam int SETTLE_CYCLES = DEPTH + 8;
	localparam int REPORT_LIMIT = 10;
	localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_LAST = 3'd7;

	typedef struct packed {
		logic [OP_W-1:0]       operation;
		logic [SLOT_NUM_W-1:0] slot_number;
		logic [FH_W-1:0]       file_handle;
	} request_word_t;

	typedef struct packed {
		dst_pkg::status_t      status;
		logic [SLOT_OUT_W-1:0] slot;
		logic [HOUT_W-1:0]     handle;
		dst_pkg::ref_t         ref_act;
		logic                  last;
	} table_result_t;

	typedef enum int {
		MODE_GROW,
		MODE_MIX,
		MODE_SHRINK
	} gen_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cmd_valid_q = 1'b0;
	logic [OP_W-1:0]       cmd_op_q = '0;
	logic [SLOT_NUM_W-1:0] cmd_slot_q = '0;
	logic [FH_W-1:0]       cmd_fh_q = '0;
	logic                  rsp_ready_q = 1'b0;

	int snd_idle_pct = 38;
	int rcv_idle_pct = 84;
	int fail_count = 0;

	logic [dst_pkg::HANDLE_BITS_DEF-1:0] slot_copy [2][DEPTH];
	request_word_t requests_to_send [$];
	table_result_t slot_results_due [$];

	dst_cmd_if cmd_ch ();
	dst_rsp_if rsp_ch ();

	assign cmd_ch.valid = cmd_valid_q;
	assign cmd_ch.operation = cmd_op_q;
	assign cmd_ch.slot_number = cmd_slot_q;
	assign cmd_ch.file_handle = cmd_fh_q;
	assign rsp_ch.ready = rsp_ready_q;

	descriptor_slot_table DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int lowest_free(input int copy);
		for (int i = 0; i < DEPTH; i++) begin
			if (slot_copy[copy][i] == '0) return i;
		end
		return DEPTH;
	endfunction

	function automatic logic [FH_W-1:0] held_handle(input int copy,
		input logic [SLOT_NUM_W-1:0] slot);
		if (slot >= DEPTH) return '0;
		return slot_copy[copy][slot];
	endfunction

	function automatic void add_result(input bit record, input dst_pkg::status_t st,
		input int slot, input logic [FH_W-1:0] h, input dst_pkg::ref_t ra, input logic lst);
		table_result_t r;
		if (record) begin
			r.status = st;
			r.slot = SLOT_OUT_W'(slot);
			r.handle = h;
			r.ref_act = ra;
			r.last = lst;
			slot_results_due.push_back(r);
		end
	endfunction

	function automatic void apply_request(input int copy, input request_word_t w,
		input bit record);
		logic [FH_W-1:0] h;
		int free_idx;
		int total;
		int k;
		h = held_handle(copy, w.slot_number);
		free_idx = lowest_free(copy);
		case (w.operation)
			dst_pkg::OP_ALLOC: begin
				if (w.file_handle == '0) begin
					add_result(record, dst_pkg::STAT_BAD_HANDLE, 0, '0, dst_pkg::REF_NONE, 1'b1);
				end else if (free_idx >= DEPTH) begin
					add_result(record, dst_pkg::STAT_FULL, 0, '0, dst_pkg::REF_NONE, 1'b1);
				end else begin
					slot_copy[copy][free_idx] = w.file_handle;
					add_result(record, dst_pkg::STAT_OK, free_idx, w.file_handle,
						dst_pkg::REF_NONE, 1'b1);
				end
			end
			dst_pkg::OP_GET: begin
				if (h == '0) begin
					add_result(record, dst_pkg::STAT_NOT_OPEN, 0, '0, dst_pkg::REF_NONE, 1'b1);
				end else begin
					add_result(record, dst_pkg::STAT_OK, int'(w.slot_number), h,
						dst_pkg::REF_NONE, 1'b1);
				end
			end
			dst_pkg::OP_CLOSE: begin
				if (h == '0) begin
					add_result(record, dst_pkg::STAT_NOT_OPEN, 0, '0, dst_pkg::REF_NONE, 1'b1);
				end else begin
					slot_copy[copy][w.slot_number] = '0;
					add_result(record, dst_pkg::STAT_OK, int'(w.slot_number), h,
						dst_pkg::REF_DROP, 1'b1);
				end
			end
			dst_pkg::OP_DUP: begin
				if (h == '0) begin
					add_result(record, dst_pkg::STAT_NOT_OPEN, 0, '0, dst_pkg::REF_NONE, 1'b1);
				end else if (free_idx >= DEPTH) begin
					add_result(record, dst_pkg::STAT_FULL, 0, '0, dst_pkg::REF_NONE, 1'b1);
				end else begin
					slot_copy[copy][free_idx] = h;
					add_result(record, dst_pkg::STAT_OK, free_idx, h, dst_pkg::REF_ADD, 1'b1);
				end
			end
			dst_pkg::OP_DESTROY: begin
				total = 0;
				for (int i = 0; i < DEPTH; i++) begin
					if (slot_copy[copy][i] != '0) total++;
				end
				k = 0;
				for (int i = 0; i < DEPTH; i++) begin
					if (slot_copy[copy][i] != '0) begin
						k++;
						add_result(record, dst_pkg::STAT_OK, i, slot_copy[copy][i],
							dst_pkg::REF_DROP, k == total);
						slot_copy[copy][i] = '0;
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void queue_request(input logic [OP_W-1:0] op,
		input logic [SLOT_NUM_W-1:0] slot, input logic [FH_W-1:0] fh);
		request_word_t w;
		w.operation = op;
		w.slot_number = slot;
		w.file_handle = fh;
		apply_request(GEN_COPY, w, 1'b0);
		requests_to_send.push_back(w);
	endfunction

	function automatic logic [SLOT_NUM_W-1:0] pick_slot();
		int r;
		int start;
		r = $urandom_range(99);
		if (r < 70 && lowest_free(GEN_COPY) != 0 || r < 70 && slot_copy[GEN_COPY][0] != '0) begin
			start = $urandom_range(DEPTH - 1);
			for (int i = 0; i < DEPTH; i++) begin
				if (slot_copy[GEN_COPY][(start + i) % DEPTH] != '0)
					return SLOT_NUM_W'((start + i) % DEPTH);
			end
		end
		if (r < 90) return SLOT_NUM_W'($urandom_range(DEPTH - 1));
		return SLOT_NUM_W'($urandom_range(255, DEPTH));
	endfunction

	function automatic logic [FH_W-1:0] pick_handle();
		int r;
		r = $urandom_range(99);
		if (r < 5) return '0;
		if (r < 8) return '1;
		if (r < 10) return FH_W'(1);
		return FH_W'($urandom_range(16'hFFFF));
	endfunction

	function automatic void queue_random_requests(input int count);
		gen_mode_t mode;
		int made;
		int left_in_mode;
		int pick;
		logic [OP_W-1:0] op;
		made = 0;
		left_in_mode = 0;
		mode = MODE_MIX;
		while (made < count) begin
			if (left_in_mode == 0) begin
				mode = gen_mode_t'($urandom_range(2));
				left_in_mode = $urandom_range(40, 10);
			end
			left_in_mode--;
			pick = $urandom_range(99);
			if (pick < 3) begin
				queue_request(OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)),
					SLOT_NUM_W'($urandom_range(255)), FH_W'($urandom_range(16'hFFFF)));
			end else begin
				pick = $urandom_range(99);
				case (mode)
					MODE_GROW: op = pick < 55 ? dst_pkg::OP_ALLOC : pick < 80 ? dst_pkg::OP_DUP :
						pick < 90 ? dst_pkg::OP_GET : pick < 97 ? dst_pkg::OP_CLOSE :
						dst_pkg::OP_DESTROY;
					MODE_SHRINK: op = pick < 10 ? dst_pkg::OP_ALLOC : pick < 30 ? dst_pkg::OP_GET :
						pick < 85 ? dst_pkg::OP_CLOSE : pick < 95 ? dst_pkg::OP_DUP :
						dst_pkg::OP_DESTROY;
					default: op = pick < 25 ? dst_pkg::OP_ALLOC : pick < 50 ? dst_pkg::OP_GET :
						pick < 72 ? dst_pkg::OP_CLOSE : pick < 96 ? dst_pkg::OP_DUP :
						dst_pkg::OP_DESTROY;
				endcase
				queue_request(op, pick_slot(), pick_handle());
				made++;
			end
		end
	endfunction

	task automatic wait_for_quiet();
		while (requests_to_send.size() != 0 || cmd_valid_q || slot_results_due.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		request_word_t w;
		request_word_t nxt;
		logic offered;
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
		end else begin
			offered = cmd_valid_q;
			if (cmd_valid_q && cmd_ch.ready) begin
				w.operation = cmd_op_q;
				w.slot_number = cmd_slot_q;
				w.file_handle = cmd_fh_q;
				apply_request(PRED_COPY, w, 1'b1);
				offered = 1'b0;
			end
			if (!offered) begin
				if (requests_to_send.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
					nxt = requests_to_send.pop_front();
					cmd_op_q <= nxt.operation;
					cmd_slot_q <= nxt.slot_number;
					cmd_fh_q <= nxt.file_handle;
					cmd_valid_q <= 1'b1;
				end else begin
					cmd_valid_q <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready_q <= 1'b0;
		end else begin
			rsp_ready_q <= $urandom_range(99) >= rcv_idle_pct;
		end
	end

	always @(posedge clk) begin
		table_result_t got;
		table_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.status = dst_pkg::status_t'(rsp_ch.status);
			got.slot = rsp_ch.slot_out;
			got.handle = rsp_ch.handle_out;
			got.ref_act = dst_pkg::ref_t'(rsp_ch.ref_action);
			got.last = rsp_ch.last;
			if (slot_results_due.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("unexpected result word: status %0d slot %0d handle %h",
						got.status, got.slot, got.handle,
						" ref %0d last %0d", got.ref_act, got.last);
			end else begin
				want = slot_results_due.pop_front();
				if (got.status !== want.status || got.slot !== want.slot ||
					got.handle !== want.handle || got.ref_act !== want.ref_act ||
					got.last !== want.last) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("result word mismatch: expected %0d/%0d/%h/%0d/%0d",
							want.status, want.slot, want.handle, want.ref_act, want.last,
							" got %0d/%0d/%h/%0d/%0d",
							got.status, got.slot, got.handle, got.ref_act, got.last);
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("descriptor_slot_table verification failed");
		$finish;
	end

	initial begin
		for (int c = 0; c < 2; c++) begin
			for (int i = 0; i < DEPTH; i++) slot_copy[c][i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		queue_request(dst_pkg::OP_ALLOC, 8'd0, 16'h0000);
		queue_request(dst_pkg::OP_ALLOC, 8'd0, 16'hFFFF);
		queue_request(dst_pkg::OP_ALLOC, 8'd0, 16'h0001);
		queue_request(dst_pkg::OP_ALLOC, 8'd0, 16'h8000);
		queue_request(dst_pkg::OP_GET, 8'd0, 16'h0000);
		queue_request(dst_pkg::OP_GET, 8'd255, 16'hFFFF);
		queue_request(dst_pkg::OP_GET, 8'd64, 16'h0000);
		queue_request(dst_pkg::OP_GET, 8'd63, 16'h0000);
		queue_request(dst_pkg::OP_CLOSE, 8'd1, 16'h0000);
		queue_request(dst_pkg::OP_CLOSE, 8'd1, 16'h0000);
		queue_request(dst_pkg::OP_DUP, 8'd0, 16'h0000);
		queue_request(dst_pkg::OP_DUP, 8'd9, 16'h0000);
		queue_request(dst_pkg::OP_DUP, 8'd200, 16'h0000);
		queue_request(dst_pkg::OP_ALLOC, 8'd0, 16'h5A5A);
		queue_request(dst_pkg::OP_CLOSE, 8'd200, 16'h0000);
		queue_request(dst_pkg::OP_DESTROY, 8'd0, 16'h0000);
		queue_request(dst_pkg::OP_DESTROY, 8'd255, 16'hFFFF);
		queue_request(OP_SPARE_FIRST, 8'd0, 16'h1234);
		queue_request(OP_SPARE_MID, 8'd17, 16'hFFFF);
		queue_request(OP_SPARE_LAST, 8'd255, 16'h0000);
		queue_request(dst_pkg::OP_ALLOC, 8'd0, 16'h00FF);
		queue_request(dst_pkg::OP_GET, 8'd0, 16'h0000);
		queue_request(dst_pkg::OP_CLOSE, 8'd0, 16'h0000);

		// Fill the table completely, then hit the full-table cases and a full destroy.
		while (lowest_free(GEN_COPY) < DEPTH)
			queue_request(dst_pkg::OP_ALLOC, SLOT_NUM_W'($urandom_range(255)),
				FH_W'($urandom_range(16'hFFFF, 1)));
		queue_request(dst_pkg::OP_ALLOC, pick_slot(), pick_handle());
		queue_request(dst_pkg::OP_DUP, pick_slot(), pick_handle());
		queue_request(dst_pkg::OP_GET, 8'd63, pick_handle());
		queue_request(dst_pkg::OP_CLOSE, 8'd63, pick_handle());
		queue_request(dst_pkg::OP_DUP, 8'd0, pick_handle());
		queue_request(dst_pkg::OP_ALLOC, pick_slot(), FH_W'($urandom_range(16'hFFFF, 1)));
		queue_request(dst_pkg::OP_DESTROY, pick_slot(), pick_handle());
		queue_random_requests(35);
		wait_for_quiet();

		snd_idle_pct = 84;
		rcv_idle_pct = 38;
		queue_random_requests(90);
		wait_for_quiet();

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		queue_random_requests(90);
		wait_for_quiet();
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (fail_count == 0 && slot_results_due.size() == 0) begin
			$display("descriptor_slot_table verification clean");
		end else begin
			$display("descriptor_slot_table verification failed");
		end
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/dst_pkg.sv
rtl/dst_cmd_if.sv
rtl/dst_rsp_if.sv
rtl/dst_ram.sv
rtl/descriptor_slot_table.sv
sim/tb.sv
